>>> hw/rtl/sorted_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent check helpers used by the queue top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");

// next-cycle implication, quiet during reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");

`endif

>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request and response types, command and status codes, cell control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int COUNT_FIELD_W    = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                       command;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]    removed_value;
      logic [1:0]                   status;
      logic [COUNT_FIELD_W-1:0]     count_after;
      logic signed [VALUE_W-1:0]    front_value;
      logic                         is_empty;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } ctrl_type;

endpackage

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: compares against the new value, takes it,
// shifts from its left neighbor on insert or from its right on remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 5
) (
   input  logic                               clock,
   input  spq_pkg::ctrl_type                  ctrl,
   input  logic [CNT_W-1:0]                   count,
   input  logic signed [spq_pkg::VALUE_W-1:0] new_value,
   input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
   input  logic                               left_gt,
   input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
   output logic signed [spq_pkg::VALUE_W-1:0] value,
   output logic                               gt
);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic signed [spq_pkg::VALUE_W-1:0] value_in;
   logic                               occupied;

   always_comb begin
      occupied = CNT_W'(INDEX) < count;
      gt       = occupied && (value_ff > new_value);
   end

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt || !occupied) begin
            value_in = new_value;
         end
      end else if (ctrl.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hw/rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// Minimum priority queue kept as a sorted chain of CAPACITY cells.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the response side stalls: every cell
// compares its entry with the new value in the same cycle and shifts by one
// slot, and the response appears in the cycle after the request is accepted,
// from an output register. A new request is taken while the held response is
// being taken, so the rate is one request per cycle unless the response side
// stalls. Reset clears the entry count and the response valid flag only; no
// clearing pass is run. Inserts go behind equal values; an insert while full
// and a remove while empty leave the queue unchanged and are flagged.
`timescale 1ns / 1ps

`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top #(
   parameter int unsigned CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   spq_pkg::rsp_type   rsp_ff;
   spq_pkg::rsp_type   rsp_in;
   spq_pkg::ctrl_type  ctrl;
   logic               req_accept;
   logic               full;
   logic               empty;
   logic signed [spq_pkg::VALUE_W-1:0] cell_value [CAPACITY];
   logic                               cell_gt    [CAPACITY];
   logic signed [spq_pkg::VALUE_W-1:0] front;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign empty      = count_ff == '0;

   always_comb begin
      ctrl.insert = req_accept && (req.command == spq_pkg::CMD_INSERT) && !full;
      ctrl.remove = req_accept && (req.command == spq_pkg::CMD_REMOVE) && !empty;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [spq_pkg::VALUE_W-1:0] left_value;
      logic                               left_gt;
      logic signed [spq_pkg::VALUE_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = req.value;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      spq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .new_value   (req.value),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // front entry after this request
   always_comb begin
      front = cell_value[0];
      if (ctrl.remove) begin
         front = cell_value[1];
      end else if (ctrl.insert && (empty || cell_gt[0])) begin
         front = req.value;
      end
   end

   always_comb begin
      rsp_in.removed_value = ctrl.remove ? cell_value[0] : '0;
      rsp_in.status        = spq_pkg::STATUS_OK;
      if (req.command == spq_pkg::CMD_INSERT && full) begin
         rsp_in.status = spq_pkg::STATUS_FULL;
      end else if (req.command == spq_pkg::CMD_REMOVE && empty) begin
         rsp_in.status = spq_pkg::STATUS_EMPTY;
      end
      rsp_in.count_after = spq_pkg::COUNT_FIELD_W'(count_in);
      rsp_in.is_empty    = count_in == '0;
      rsp_in.front_value = (count_in == '0) ? '0 : front;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SPQ_ASSERT_NOW(a_head_order, count_ff >= CNT_W'(2), cell_value[0] <= cell_value[1])
   `SPQ_ASSERT_NOW(a_empty_flag, rsp_valid_ff, rsp_ff.is_empty == (count_ff == '0))
   `SPQ_ASSERT_NEXT(a_full_refused, req_accept && req.command == spq_pkg::CMD_INSERT && full, rsp_valid_ff && rsp_ff.status == spq_pkg::STATUS_FULL && $stable(count_ff))

endmodule
